// ===== rtl/fwps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the fill/wait pump sequencer: key codes, menu state type,
// beat widths and the time helper functions. No dependencies.
package fwps_pkg;

  localparam int unsigned InWidth  = 8;
  localparam int unsigned OutWidth = 56;

  localparam logic [2:0] KEY_NONE  = 3'd0;
  localparam logic [2:0] KEY_UP    = 3'd1;
  localparam logic [2:0] KEY_DN    = 3'd2;
  localparam logic [2:0] KEY_ENTER = 3'd3;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [6:0] CENTI_MAX = 7'd90;
  localparam logic [6:0] CENTI_STEP = 7'd10;

  localparam logic [2:0] STEP_MAIN       = 3'd0;
  localparam logic [2:0] STEP_FILL_SEC   = 3'd1;
  localparam logic [2:0] STEP_FILL_CENTI = 3'd2;
  localparam logic [2:0] STEP_WAIT_SEC   = 3'd3;
  localparam logic [2:0] STEP_WAIT_CENTI = 3'd4;

  typedef enum logic [4:0] {
    MENU_MAIN       = 5'b00001,
    MENU_FILL_SEC   = 5'b00010,
    MENU_FILL_CENTI = 5'b00100,
    MENU_WAIT_SEC   = 5'b01000,
    MENU_WAIT_CENTI = 5'b10000
  } menu_t;

  // Seconds and centiseconds to milliseconds.
  function automatic logic [15:0] to_ms(input logic [5:0] sec, input logic [6:0] centi);
    to_ms = 16'(16'(sec) * 16'd1000) + 16'(16'(centi) * 16'd10);
  endfunction

  // Seconds field: wrap 0..59 both ways.
  function automatic logic [5:0] step_sec(input logic [5:0] v, input logic [2:0] key);
    step_sec = v;
    if (key == KEY_UP) begin
      step_sec = (v < SEC_MAX) ? v + 6'd1 : 6'd0;
    end else if (key == KEY_DN) begin
      step_sec = (v > 6'd0) ? v - 6'd1 : SEC_MAX;
    end
  endfunction

  // Centisecond field: steps of ten, wrap 0..90 both ways.
  function automatic logic [6:0] step_centi(input logic [6:0] v, input logic [2:0] key);
    step_centi = v;
    if (key == KEY_UP) begin
      step_centi = (v < CENTI_MAX) ? v + CENTI_STEP : 7'd0;
    end else if (key == KEY_DN) begin
      step_centi = (v > 7'd0) ? v - CENTI_STEP : CENTI_MAX;
    end
  endfunction

endpackage

// ===== rtl/fill_wait_pump_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the fill/wait pump sequencer: menu, manual fill, auto cycle
// and output staging. Depends on fwps_pkg.

// One input beat is one 1 ms tick; it takes one beat per clock cycle while
// in_tready is high, and each beat gives exactly one registered result beat.
// The state update is a single pass of small counters, compares and
// two constant multiplies (seconds*1000 + centis*10) from the state registers
// into the result register. A result register plus a one-deep skid register
// sit on the result side, so in_tready drops only when both hold beats that
// the downstream side has not yet taken. Results are the state after the
// tick: pump and lamp levels, bottle count, menu step and both times in ms.
module fill_wait_pump_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] manual_button, [1] clear_button, [2] auto_button, [5:3] key_code
  input  logic [fwps_pkg::InWidth-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] pump_on, [1] pump_lamp, [2] auto_lamp, [18:3] bottle_count,
  // [21:19] menu_step, [37:22] fill_ms, [53:38] wait_ms
  output logic [fwps_pkg::OutWidth-1:0]     out_tdata
);

  // Unpack the input beat.
  logic       man_lvl, clr_lvl, auto_lvl;
  logic [2:0] key;
  assign man_lvl  = in_tdata[0];
  assign clr_lvl  = in_tdata[1];
  assign auto_lvl = in_tdata[2];
  assign key      = in_tdata[5:3];

  logic in_accept;
  assign in_accept = in_tvalid & in_tready;

  // State registers.
  fwps_pkg::menu_t menu_r, menu_nxt;
  logic [5:0]  fill_sec_r, fill_sec_nxt, wait_sec_r, wait_sec_nxt;
  logic [6:0]  fill_cen_r, fill_cen_nxt, wait_cen_r, wait_cen_nxt;
  logic [15:0] bottles_r, bottles_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] phase_len_r, phase_len_nxt;
  logic [15:0] manual_r, manual_nxt;
  logic        phase_fill_r, phase_fill_nxt;
  logic        pump_r, pump_nxt;
  logic        lamp_r, lamp_nxt;
  logic        auto_lamp_r, auto_lamp_nxt;

  logic [15:0] fill_ms_cur, wait_ms_cur;
  logic        do_rest;

  assign fill_ms_cur = fwps_pkg::to_ms(fill_sec_r, fill_cen_r);
  assign wait_ms_cur = fwps_pkg::to_ms(wait_sec_r, wait_cen_r);

  always_comb begin
    menu_nxt       = menu_r;
    fill_sec_nxt   = fill_sec_r;
    fill_cen_nxt   = fill_cen_r;
    wait_sec_nxt   = wait_sec_r;
    wait_cen_nxt   = wait_cen_r;
    bottles_nxt    = bottles_r;
    phase_len_nxt  = phase_len_r;
    manual_nxt     = manual_r;
    phase_fill_nxt = phase_fill_r;
    pump_nxt       = pump_r;
    lamp_nxt       = lamp_r;
    auto_lamp_nxt  = auto_lamp_r;
    do_rest        = 1'b0;

    // Elapsed time saturates at full scale.
    ticks_nxt = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;

    case (menu_r)
      fwps_pkg::MENU_FILL_SEC: begin
        if (key == fwps_pkg::KEY_ENTER) menu_nxt = fwps_pkg::MENU_FILL_CENTI;
        else fill_sec_nxt = fwps_pkg::step_sec(fill_sec_r, key);
      end
      fwps_pkg::MENU_FILL_CENTI: begin
        if (key == fwps_pkg::KEY_ENTER) menu_nxt = fwps_pkg::MENU_WAIT_SEC;
        else fill_cen_nxt = fwps_pkg::step_centi(fill_cen_r, key);
      end
      fwps_pkg::MENU_WAIT_SEC: begin
        if (key == fwps_pkg::KEY_ENTER) menu_nxt = fwps_pkg::MENU_WAIT_CENTI;
        else wait_sec_nxt = fwps_pkg::step_sec(wait_sec_r, key);
      end
      fwps_pkg::MENU_WAIT_CENTI: begin
        if (key == fwps_pkg::KEY_ENTER) menu_nxt = fwps_pkg::MENU_MAIN;
        else wait_cen_nxt = fwps_pkg::step_centi(wait_cen_r, key);
      end
      default: begin
        menu_nxt = fwps_pkg::MENU_MAIN;
        if (manual_r != 16'd0) begin
          // Manual fill running: count down, ignore inputs until it ends.
          manual_nxt = manual_r - 16'd1;
          if (manual_nxt == 16'd0) begin
            pump_nxt = 1'b0;
            lamp_nxt = 1'b0;
            do_rest  = 1'b1;
          end
        end else if (man_lvl) begin
          manual_nxt = fill_ms_cur;
          pump_nxt   = 1'b1;
          lamp_nxt   = 1'b1;
          if (fill_ms_cur == 16'd0) begin
            // Zero fill time: pump drops in the same tick.
            pump_nxt = 1'b0;
            lamp_nxt = 1'b0;
            do_rest  = 1'b1;
          end
        end else begin
          do_rest = 1'b1;
        end

        if (do_rest) begin
          if (clr_lvl) bottles_nxt = 16'd0;
          if (auto_lvl) begin
            auto_lamp_nxt = 1'b1;
            if (ticks_nxt >= phase_len_r) begin
              ticks_nxt      = 16'd0;
              phase_fill_nxt = ~phase_fill_r;
              pump_nxt       = ~phase_fill_r;
              lamp_nxt       = ~phase_fill_r;
              if (!phase_fill_r) begin
                phase_len_nxt = fill_ms_cur;
                bottles_nxt   = bottles_nxt + 16'd1;
              end else begin
                phase_len_nxt = wait_ms_cur;
              end
            end
          end else begin
            pump_nxt      = 1'b0;
            auto_lamp_nxt = 1'b0;
          end
          if (key == fwps_pkg::KEY_ENTER) menu_nxt = fwps_pkg::MENU_FILL_SEC;
        end
      end
    endcase
  end

  // Encode the menu position for the result beat.
  logic [2:0] step_code;
  always_comb begin
    case (menu_nxt)
      fwps_pkg::MENU_FILL_SEC:   step_code = fwps_pkg::STEP_FILL_SEC;
      fwps_pkg::MENU_FILL_CENTI: step_code = fwps_pkg::STEP_FILL_CENTI;
      fwps_pkg::MENU_WAIT_SEC:   step_code = fwps_pkg::STEP_WAIT_SEC;
      fwps_pkg::MENU_WAIT_CENTI: step_code = fwps_pkg::STEP_WAIT_CENTI;
      default:                   step_code = fwps_pkg::STEP_MAIN;
    endcase
  end

  logic [fwps_pkg::OutWidth-1:0] result;
  assign result = {2'b00,
                   fwps_pkg::to_ms(wait_sec_nxt, wait_cen_nxt),
                   fwps_pkg::to_ms(fill_sec_nxt, fill_cen_nxt),
                   step_code, bottles_nxt, auto_lamp_nxt, lamp_nxt, pump_nxt};

  // Advance state on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r       <= fwps_pkg::MENU_MAIN;
      fill_sec_r   <= '0;
      fill_cen_r   <= '0;
      wait_sec_r   <= '0;
      wait_cen_r   <= '0;
      bottles_r    <= '0;
      ticks_r      <= '0;
      phase_len_r  <= '0;
      manual_r     <= '0;
      phase_fill_r <= 1'b0;
      pump_r       <= 1'b0;
      lamp_r       <= 1'b0;
      auto_lamp_r  <= 1'b0;
    end else if (in_accept) begin
      menu_r       <= menu_nxt;
      fill_sec_r   <= fill_sec_nxt;
      fill_cen_r   <= fill_cen_nxt;
      wait_sec_r   <= wait_sec_nxt;
      wait_cen_r   <= wait_cen_nxt;
      bottles_r    <= bottles_nxt;
      ticks_r      <= ticks_nxt;
      phase_len_r  <= phase_len_nxt;
      manual_r     <= manual_nxt;
      phase_fill_r <= phase_fill_nxt;
      pump_r       <= pump_nxt;
      lamp_r       <= lamp_nxt;
      auto_lamp_r  <= auto_lamp_nxt;
    end
  end

  // Result register with a one-deep skid behind it.
  logic                          out_valid_r, skid_valid_r;
  logic [fwps_pkg::OutWidth-1:0] out_data_r, skid_data_r;

  assign in_tready  = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      // Result slot frees up: refill from skid first, else from the new beat.
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      // Downstream stalled: park the new beat.
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) out_data_r <= skid_data_r;
      else if (in_accept) out_data_r <= result;
    end else if (in_accept) begin
      skid_data_r <= result;
    end
  end

  // The skid only holds a beat behind a full result register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the result register is empty");

  // A beat taken during an output stall must land in the skid.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_accept && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("beat accepted under stall was not parked");

  // A running manual fill keeps the pump driven.
  assert property (@(posedge clk) disable iff (!rst_n) (manual_r != 16'd0) |-> pump_r)
    else $error("pump off during manual fill countdown");

  // The bottle count moves only on an accepted tick.
  assert property (@(posedge clk) disable iff (!rst_n) !in_accept |=> $stable(bottles_r))
    else $error("bottle count changed without a tick");

endmodule

// ===== tb/sv/tb_fill_wait_pump_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fill_wait_pump_sequencer: drives 1 ms tick beats, predicts
// each result beat in a local model of the menu, manual and auto logic, and checks it.
// Depends on fwps_pkg and the fill_wait_pump_sequencer RTL.
module tb_fill_wait_pump_sequencer;

  // Key codes above KEY_ENTER mean nothing to the block.
  localparam logic [2:0] KEY_OTHER_FIRST = 3'd4;
  localparam logic [2:0] KEY_OTHER_LAST  = 3'd7;

  localparam int MS_PER_SEC     = 1000;
  localparam int MS_PER_CENTI   = 10;
  localparam int SEC_SPAN       = fwps_pkg::SEC_MAX + 1;
  localparam int CENTI_SPAN     = fwps_pkg::CENTI_MAX / fwps_pkg::CENTI_STEP + 1;
  localparam int MANUAL_CAP_MS  = 100;     // keep random manual fills short
  localparam int RANDOM_TICKS   = 950;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // Input beat, lowest bit first: manual, clear, auto switch, key code.
  typedef struct packed {
    logic [2:0] key;
    logic       auto_sw;
    logic       clear;
    logic       manual;
  } tick_t;

  // Result beat, lowest bit first: pump, pump lamp, auto lamp, bottles, step, times.
  typedef struct packed {
    logic [15:0] wait_ms;
    logic [15:0] fill_ms;
    logic [2:0]  menu_step;
    logic [15:0] bottle_count;
    logic        auto_lamp;
    logic        pump_lamp;
    logic        pump_on;
  } panel_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [fwps_pkg::InWidth-1:0]   in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [fwps_pkg::OutWidth-1:0]  out_tdata;

  fill_wait_pump_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predicted machine state, all zero out of reset.
  logic [2:0]  p_menu        = fwps_pkg::STEP_MAIN;
  logic [5:0]  p_fill_sec    = '0;
  logic [6:0]  p_fill_cs     = '0;
  logic [5:0]  p_wait_sec    = '0;
  logic [6:0]  p_wait_cs     = '0;
  logic [15:0] p_bottles     = '0;
  logic [15:0] p_since       = '0;
  logic [15:0] p_phase_len   = '0;
  logic [15:0] p_manual_left = '0;
  logic        p_in_fill     = 1'b0;
  logic        p_pump        = 1'b0;
  logic        p_pump_lamp   = 1'b0;
  logic        p_auto_lamp   = 1'b0;

  panel_t      expected_panels[$];
  int unsigned ticks_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          tx_gaps        = 1'b1;
  bit          rx_gaps        = 1'b1;
  int          hold_request   = 0;

  function automatic logic [15:0] duration_ms(input logic [5:0] s, input logic [6:0] c);
    return 16'(int'(s) * MS_PER_SEC + int'(c) * MS_PER_CENTI);
  endfunction

  function automatic logic [5:0] next_seconds(input logic [5:0] v, input logic [2:0] k);
    case (k)
      fwps_pkg::KEY_UP: return (v == fwps_pkg::SEC_MAX) ? 6'd0 : v + 6'd1;
      fwps_pkg::KEY_DN: return (v == 6'd0) ? fwps_pkg::SEC_MAX : v - 6'd1;
      default:          return v;
    endcase
  endfunction

  function automatic logic [6:0] next_centis(input logic [6:0] v, input logic [2:0] k);
    case (k)
      fwps_pkg::KEY_UP: return (v == fwps_pkg::CENTI_MAX) ? 7'd0 : v + fwps_pkg::CENTI_STEP;
      fwps_pkg::KEY_DN: return (v == 7'd0) ? fwps_pkg::CENTI_MAX : v - fwps_pkg::CENTI_STEP;
      default:          return v;
    endcase
  endfunction

  // Advance the predicted state by one tick and return the panel it shows.
  function automatic panel_t advance_tick(input tick_t t);
    panel_t p;
    bit     run_main;
    if (p_since != 16'hFFFF) p_since++;
    case (p_menu)
      fwps_pkg::STEP_FILL_SEC: begin
        if (t.key == fwps_pkg::KEY_ENTER) p_menu = fwps_pkg::STEP_FILL_CENTI;
        else p_fill_sec = next_seconds(p_fill_sec, t.key);
      end
      fwps_pkg::STEP_FILL_CENTI: begin
        if (t.key == fwps_pkg::KEY_ENTER) p_menu = fwps_pkg::STEP_WAIT_SEC;
        else p_fill_cs = next_centis(p_fill_cs, t.key);
      end
      fwps_pkg::STEP_WAIT_SEC: begin
        if (t.key == fwps_pkg::KEY_ENTER) p_menu = fwps_pkg::STEP_WAIT_CENTI;
        else p_wait_sec = next_seconds(p_wait_sec, t.key);
      end
      fwps_pkg::STEP_WAIT_CENTI: begin
        if (t.key == fwps_pkg::KEY_ENTER) p_menu = fwps_pkg::STEP_MAIN;
        else p_wait_cs = next_centis(p_wait_cs, t.key);
      end
      default: begin
        p_menu   = fwps_pkg::STEP_MAIN;
        run_main = 1'b1;
        // A running manual fill swallows every tick but the one that ends it.
        if (p_manual_left != 0) begin
          p_manual_left--;
          if (p_manual_left != 0) begin
            run_main = 1'b0;
          end else begin
            p_pump      = 1'b0;
            p_pump_lamp = 1'b0;
          end
        end else if (t.manual) begin
          p_manual_left = duration_ms(p_fill_sec, p_fill_cs);
          p_pump        = (p_manual_left != 0);
          p_pump_lamp   = (p_manual_left != 0);
          run_main      = (p_manual_left == 0);
        end
        if (run_main) begin
          // Clear comes before the auto bottle count of the same tick.
          if (t.clear) p_bottles = '0;
          if (t.auto_sw) begin
            p_auto_lamp = 1'b1;
            if (p_since >= p_phase_len) begin
              p_since     = '0;
              p_in_fill   = ~p_in_fill;
              p_pump      = p_in_fill;
              p_pump_lamp = p_in_fill;
              if (p_in_fill) begin
                p_phase_len = duration_ms(p_fill_sec, p_fill_cs);
                p_bottles++;
              end else begin
                p_phase_len = duration_ms(p_wait_sec, p_wait_cs);
              end
            end
          end else begin
            p_pump      = 1'b0;
            p_auto_lamp = 1'b0;
          end
          if (t.key == fwps_pkg::KEY_ENTER) p_menu = fwps_pkg::STEP_FILL_SEC;
        end
      end
    endcase
    p.pump_on      = p_pump;
    p.pump_lamp    = p_pump_lamp;
    p.auto_lamp    = p_auto_lamp;
    p.bottle_count = p_bottles;
    p.menu_step    = p_menu;
    p.fill_ms      = duration_ms(p_fill_sec, p_fill_cs);
    p.wait_ms      = duration_ms(p_wait_sec, p_wait_cs);
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    panel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = panel_t'(out_tdata[$bits(panel_t)-1:0]);
      if (expected_panels.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want = expected_panels.pop_front();
        check_field("pump_on", got.pump_on, want.pump_on);
        check_field("pump_lamp", got.pump_lamp, want.pump_lamp);
        check_field("auto_lamp", got.auto_lamp, want.auto_lamp);
        check_field("bottle_count", got.bottle_count, want.bottle_count);
        check_field("menu_step", got.menu_step, want.menu_step);
        check_field("fill_ms", got.fill_ms, want.fill_ms);
        check_field("wait_ms", got.wait_ms, want.wait_ms);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, a stall-free mode, and a counted hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        out_tready <= rx_gaps ? ($urandom_range(99) >= 13) : 1'b1;
      end
    end
  end

  // Offer one tick beat, hold it until accepted, then queue its prediction.
  // Valid stays high afterwards so back-to-back beats need no extra edge.
  task automatic send_tick(input tick_t t);
    while (tx_gaps && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= fwps_pkg::InWidth'(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_panels.push_back(advance_tick(t));
    ticks_sent++;
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_panels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t make_tick(input bit m, input bit c, input bit a,
                                      input logic [2:0] k);
    tick_t t;
    t.manual  = m;
    t.clear   = c;
    t.auto_sw = a;
    t.key     = k;
    return t;
  endfunction

  function automatic logic [2:0] idle_key();
    return $urandom_range(1) ? fwps_pkg::KEY_NONE
                             : 3'($urandom_range(KEY_OTHER_LAST, KEY_OTHER_FIRST));
  endfunction

  function automatic bit manual_ok();
    return duration_ms(p_fill_sec, p_fill_cs) <= MANUAL_CAP_MS;
  endfunction

  // Fully random tick; suppress manual starts that would run for ages.
  function automatic tick_t random_tick();
    tick_t t;
    t = tick_t'(6'($urandom));
    if (!manual_ok()) t.manual = 1'b0;
    return t;
  endfunction

  // Menu steps ignore the buttons, so fill them with noise.
  function automatic tick_t menu_tick(input logic [2:0] k);
    tick_t t;
    t     = tick_t'(6'($urandom));
    t.key = k;
    return t;
  endfunction

  function automatic logic [2:0] toward(input int cur, input int target, input int span);
    return ((target - cur + span) % span <= span / 2) ? fwps_pkg::KEY_UP : fwps_pkg::KEY_DN;
  endfunction

  function automatic logic [5:0] pick_seconds();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 6'd0;
    if (r < 95) return 6'd1;
    return 6'($urandom_range(fwps_pkg::SEC_MAX));
  endfunction

  function automatic logic [6:0] pick_centis();
    return 7'($urandom_range(CENTI_SPAN - 1) * fwps_pkg::CENTI_STEP);
  endfunction

  // Walk the menu from wherever it is and dial in both times the short way round.
  task automatic program_times(input logic [5:0] fs, input logic [6:0] fc,
                               input logic [5:0] ws, input logic [6:0] wc,
                               input bit auto_level);
    while (p_manual_left != 0) send_tick(make_tick(1'b0, 1'b0, auto_level, idle_key()));
    while (p_menu != fwps_pkg::STEP_MAIN) send_tick(menu_tick(fwps_pkg::KEY_ENTER));
    send_tick(make_tick(1'b0, 1'b0, auto_level, fwps_pkg::KEY_ENTER));
    while (p_fill_sec != fs) send_tick(menu_tick(toward(p_fill_sec, fs, SEC_SPAN)));
    send_tick(menu_tick(fwps_pkg::KEY_ENTER));
    while (p_fill_cs != fc)
      send_tick(menu_tick(toward(p_fill_cs / fwps_pkg::CENTI_STEP,
                                 fc / fwps_pkg::CENTI_STEP, CENTI_SPAN)));
    send_tick(menu_tick(fwps_pkg::KEY_ENTER));
    while (p_wait_sec != ws) send_tick(menu_tick(toward(p_wait_sec, ws, SEC_SPAN)));
    send_tick(menu_tick(fwps_pkg::KEY_ENTER));
    while (p_wait_cs != wc)
      send_tick(menu_tick(toward(p_wait_cs / fwps_pkg::CENTI_STEP,
                                 wc / fwps_pkg::CENTI_STEP, CENTI_SPAN)));
    send_tick(menu_tick(fwps_pkg::KEY_ENTER));
  endtask

  // Mostly auto on with idle keys; the odd clear, manual press, arrow or select.
  task automatic run_auto_stretch(input int n);
    tick_t t;
    int    r;
    for (int i = 0; i < n; i++) begin
      r         = $urandom_range(99);
      t.manual  = manual_ok() && ($urandom_range(99) < 2);
      t.clear   = ($urandom_range(99) < 4);
      t.auto_sw = ($urandom_range(99) < 96);
      t.key     = (r < 2) ? fwps_pkg::KEY_ENTER :
                  (r < 5) ? fwps_pkg::KEY_UP :
                  (r < 8) ? fwps_pkg::KEY_DN : idle_key();
      send_tick(t);
    end
  endtask

  // Press manual, then throw noise at the block until the fill runs out.
  task automatic run_manual_fill();
    tick_t t;
    if (!manual_ok())
      program_times(6'd0, fwps_pkg::CENTI_STEP, p_wait_sec, p_wait_cs, 1'b0);
    while (p_menu != fwps_pkg::STEP_MAIN) send_tick(menu_tick(fwps_pkg::KEY_ENTER));
    t        = random_tick();
    t.manual = 1'b1;
    send_tick(t);
    while (p_manual_left != 0) send_tick(random_tick());
  endtask

  // Edges first: unused keys, zero-length fill, clear with auto, menu wraps both ways.
  task automatic test_directed_edges();
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_NONE));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, KEY_OTHER_FIRST));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, KEY_OTHER_LAST));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, fwps_pkg::KEY_NONE));   // zero fill time ends at once
    send_tick(make_tick(1'b0, 1'b0, 1'b1, fwps_pkg::KEY_NONE));   // zero phases toggle each tick
    send_tick(make_tick(1'b0, 1'b0, 1'b1, KEY_OTHER_LAST));
    send_tick(make_tick(1'b0, 1'b1, 1'b1, fwps_pkg::KEY_NONE));   // clear, then count
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_NONE));   // auto off keeps the pump lamp
    send_tick(make_tick(1'b1, 1'b1, 1'b1, fwps_pkg::KEY_ENTER));  // everything in one tick
    send_tick(make_tick(1'b1, 1'b1, 1'b1, fwps_pkg::KEY_DN));     // seconds wrap down
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_UP));     // and back up
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, KEY_OTHER_FIRST));      // unused key in a menu step
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_ENTER));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));     // centis wrap down
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_UP));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));     // fill at its maximum
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_ENTER));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_ENTER));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));     // wait at its maximum
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_ENTER));  // last step back to main
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_UP));     // arrows do nothing in main
    send_tick(make_tick(1'b0, 1'b0, 1'b0, fwps_pkg::KEY_DN));
    drain_results();
  endtask

  // A real manual fill with auto held on, and a press held across the end.
  task automatic test_manual_fill();
    program_times(6'd0, 7'd20, 6'd0, 7'd30, 1'b0);
    send_tick(make_tick(1'b1, 1'b0, 1'b1, fwps_pkg::KEY_NONE));
    while (p_manual_left != 0) send_tick(random_tick());
    repeat (4) send_tick(make_tick(1'b1, 1'b0, 1'b0, fwps_pkg::KEY_NONE));
    while (p_manual_left != 0) send_tick(make_tick(1'b0, 1'b1, 1'b1, idle_key()));
    drain_results();
  endtask

  // Hold the result side off while beats keep coming, so the input stalls.
  task automatic test_receiver_holdoff();
    program_times(6'd0, 7'd10, 6'd0, 7'd10, 1'b1);
    tx_gaps      = 1'b0;
    hold_request = HOLDOFF_CYCLES;
    run_auto_stretch(48);
    tx_gaps = 1'b1;
    drain_results();
  endtask

  // Full rate on both sides for a while.
  task automatic test_no_idle_stretch();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_auto_stretch(300);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Mix of reprogramming, auto runs, manual fills and raw noise.
  task automatic test_random_sequences();
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_TICKS) begin
      case ($urandom_range(9))
        0, 1:       program_times(pick_seconds(), pick_centis(), pick_seconds(),
                                  pick_centis(), 1'($urandom_range(1)));
        2, 3, 4, 5: run_auto_stretch($urandom_range(300, 40));
        6, 7:       run_manual_fill();
        default:    repeat ($urandom_range(40, 10)) send_tick(random_tick());
      endcase
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_manual_fill();
    test_receiver_holdoff();
    test_no_idle_stretch();
    test_random_sequences();
    drain_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
